FILE: sv/tiv_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and character helpers for the tax id check-and-pack block
// no dependencies

package tiv_pkg;

  localparam int STORE_LEN = 14;
  localparam int STEP_W    = 4;
  localparam logic [3:0] COUNT_MAX = 4'd15;
  localparam logic [3:0] COUNT_FULL = 4'd14;
  localparam logic [3:0] COUNT_ELEVEN = 4'd11;
  localparam logic [3:0] LAST_STEP = 4'd13;
  localparam logic [3:0] CHECK_LEN = 4'd12;
  localparam logic [3:0] ELEVEN_FIRST = 4'd3;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  localparam logic [63:0] CODE_INVALID = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam int ACC_A_W = 63;  // base-36 value of 12 chars
  localparam int ACC_B_W = 57;  // base-36 value of 11 chars
  localparam int ACC_D_W = 44;  // decimal value of 13 digits

  typedef enum logic [1:0] {
    KIND_CHECKED = 2'd0,
    KIND_ELEVEN  = 2'd1,
    KIND_DIGITS  = 2'd2,
    KIND_INVALID = 2'd3
  } code_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              clear;
    logic              step_en;
    logic [STEP_W-1:0] step;
  } eval_ctl_t;

  typedef struct packed {
    logic [63:0] code;
    code_kind_t  kind;
  } eval_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // 0..35 for an alphanumeric char
  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c < 8'h41) begin
      v = c - 8'h30;
    end else if (c < 8'h61) begin
      v = c - 8'h41 + 8'd10;
    end else begin
      v = c - 8'h61 + 8'd10;
    end
    return v[5:0];
  endfunction

  // upper-cased code minus 48
  function automatic logic [5:0] weight_value(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= 8'h61) ? (c - 8'h20) : c;
    u = u - 8'h30;
    return u[5:0];
  endfunction

  // reduce a value below 128 modulo 11
  function automatic logic [3:0] mod11(input logic [6:0] x);
    logic [6:0] r;
    r = x;
    if (r >= 7'd88) r = r - 7'd88;
    if (r >= 7'd44) r = r - 7'd44;
    if (r >= 7'd22) r = r - 7'd22;
    if (r >= 7'd11) r = r - 7'd11;
    return r[3:0];
  endfunction

  function automatic logic [3:0] weight_first(input logic [3:0] idx);
    logic [3:0] w;
    case (idx)
      4'd0:    w = 4'd5;
      4'd1:    w = 4'd4;
      4'd2:    w = 4'd3;
      4'd3:    w = 4'd2;
      4'd4:    w = 4'd9;
      4'd5:    w = 4'd8;
      4'd6:    w = 4'd7;
      4'd7:    w = 4'd6;
      4'd8:    w = 4'd5;
      4'd9:    w = 4'd4;
      4'd10:   w = 4'd3;
      4'd11:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] weight_second(input logic [3:0] idx);
    logic [3:0] w;
    case (idx)
      4'd0:    w = 4'd6;
      4'd1:    w = 4'd5;
      4'd2:    w = 4'd4;
      4'd3:    w = 4'd3;
      4'd4:    w = 4'd2;
      4'd5:    w = 4'd9;
      4'd6:    w = 4'd8;
      4'd7:    w = 4'd7;
      4'd8:    w = 4'd6;
      4'd9:    w = 4'd5;
      4'd10:   w = 4'd4;
      4'd11:   w = 4'd3;
      4'd12:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/tiv_cell.sv
`timescale 1ns / 1ps
// one character cell of the store chain, loads its neighbor's char on shift
// depends on tiv_pkg

module tiv_cell
  import tiv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  logic [7:0] din,
  output logic [7:0] dout
);

  logic [7:0] ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= ASCII_ZERO;
    end else if (shift) begin
      ch <= din;
    end
  end

  assign dout = ch;

endmodule

FILE: sv/tiv_eval.sv
`timescale 1ns / 1ps
// evaluation unit: takes the head char of the chain once per step and builds
// the check sums and packed values; depends on tiv_pkg

module tiv_eval
  import tiv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  eval_ctl_t  ctl,
  input  logic [7:0] head,
  input  logic [3:0] count,
  output eval_res_t  res
);

  logic [ACC_A_W-1:0] acc_a, acc_a_next;
  logic [ACC_B_W-1:0] acc_b, acc_b_next;
  logic [ACC_D_W-1:0] acc_d, acc_d_next;
  logic [3:0] s1, s1_next;
  logic [3:0] s2, s2_next;
  logic       all_dig, dig12, dig13;
  logic [3:0] v12, v13;

  logic [5:0] dv;
  logic [3:0] wr;
  logic [3:0] d1, d2, r2;
  logic       checks_ok;

  assign dv = digit_value(head);
  assign wr = mod11({1'b0, weight_value(head)});

  always_comb begin
    acc_a_next = {acc_a[ACC_A_W-6:0], 5'b0} + {acc_a[ACC_A_W-3:0], 2'b0}
                 + ACC_A_W'(dv);
    acc_b_next = {acc_b[ACC_B_W-6:0], 5'b0} + {acc_b[ACC_B_W-3:0], 2'b0}
                 + ACC_B_W'(dv);
    acc_d_next = {acc_d[ACC_D_W-4:0], 3'b0} + {acc_d[ACC_D_W-2:0], 1'b0}
                 + ACC_D_W'(dv[3:0]);
    s1_next = mod11(7'(s1) + (7'(weight_first(ctl.step)) * 7'(wr)));
    s2_next = mod11(7'(s2) + (7'(weight_second(ctl.step)) * 7'(wr)));
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      acc_a   <= '0;
      acc_b   <= '0;
      acc_d   <= '0;
      s1      <= '0;
      s2      <= '0;
      all_dig <= 1'b1;
      dig12   <= 1'b0;
      dig13   <= 1'b0;
      v12     <= '0;
      v13     <= '0;
    end else if (ctl.step_en) begin
      if (ctl.step < CHECK_LEN) begin
        acc_a <= acc_a_next;
        s1    <= s1_next;
        s2    <= s2_next;
      end
      if (ctl.step >= ELEVEN_FIRST) begin
        acc_b <= acc_b_next;
      end
      if (ctl.step != '0) begin
        acc_d   <= acc_d_next;
        all_dig <= all_dig & is_digit(head);
      end
      if (ctl.step == CHECK_LEN) begin
        dig12 <= is_digit(head);
        v12   <= dv[3:0];
      end
      if (ctl.step == LAST_STEP) begin
        dig13 <= is_digit(head);
        v13   <= dv[3:0];
      end
    end
  end

  // check digits from the finished sums
  always_comb begin
    d1 = (s1 < 4'd2) ? 4'd0 : (4'd11 - s1);
    r2 = mod11(7'(s2) + {2'b0, d1, 1'b0});
    d2 = (r2 < 4'd2) ? 4'd0 : (4'd11 - r2);
    checks_ok = dig12 && dig13 && (d1 == v12) && (d2 == v13);
  end

  always_comb begin
    res.code = CODE_INVALID;
    res.kind = KIND_INVALID;
    if (count > COUNT_FULL) begin
      res.code = CODE_INVALID;
      res.kind = KIND_INVALID;
    end else if (checks_ok) begin
      res.code = 64'(acc_a);
      res.kind = KIND_CHECKED;
    end else if (count == COUNT_FULL) begin
      res.code = CODE_INVALID;
      res.kind = KIND_INVALID;
    end else if (count <= COUNT_ELEVEN) begin
      res.code = {1'b1, 6'b0, acc_b};
      res.kind = KIND_ELEVEN;
    end else if (all_dig) begin
      res.code = {2'b11, 18'b0, acc_d};
      res.kind = KIND_DIGITS;
    end
  end

endmodule

FILE: sv/tax_id_validate_pack.sv
`timescale 1ns / 1ps
// Checks a masked tax identifier streamed one character per word and packs it
// into a 64-bit code with a kind. Characters that are not letters or digits are
// dropped; the rightmost 14 are held in a chain of 14 character cells. A word
// without tlast is taken whenever idle. A word with tlast starts an evaluation:
// the chain rotates its 14 characters past the evaluation unit, one per cycle,
// while zeros fill in behind, so the store is clear again when it finishes.
// After a tlast word no new word is taken until the chain steps are done and
// the result is loaded into the result register, later if that register is
// still waiting on m_axis_tready. Depends on tiv_pkg, tiv_cell, tiv_eval.

module tax_id_validate_pack
  import tiv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] packed_code
  output logic [1:0]  m_axis_tuser    // [1:0] code_kind
);

  state_t state, state_next;
  logic [STEP_W-1:0] step;
  logic [3:0] count;
  logic [7:0] cells [STORE_LEN];
  logic [7:0] feed;
  logic       accept, shift, load_out;
  logic       step_en;
  eval_ctl_t  ctl;
  eval_res_t  res;
  logic        out_valid;
  logic [63:0] out_code;
  logic [1:0]  out_kind;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && s_axis_tlast) state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (step == LAST_STEP) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    step_en       = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_SHIFT: step_en       = 1'b1;
      ST_DONE:  load_out      = !out_valid || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign ctl.step_en = step_en;
  assign ctl.clear   = accept && s_axis_tlast;
  assign ctl.step    = step;
  assign shift = (accept && is_alnum(s_axis_tdata)) || ctl.step_en;
  // zeros enter behind the rotating chars during evaluation
  assign feed  = ctl.step_en ? ASCII_ZERO : s_axis_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (ctl.step_en) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
      if (load_out) begin
        count <= '0;
      end else if (accept && is_alnum(s_axis_tdata) && (count != COUNT_MAX)) begin
        count <= count + 1'b1;
      end
    end
  end

  for (genvar i = 0; i < STORE_LEN; i++) begin : g_chain
    if (i == STORE_LEN - 1) begin : g_tail
      tiv_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .din  (feed),
        .dout (cells[i])
      );
    end else begin : g_body
      tiv_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .din  (cells[i+1]),
        .dout (cells[i])
      );
    end
  end

  tiv_eval u_eval (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .head (cells[0]),
    .count(count),
    .res  (res)
  );

  // output register parts the result from the input side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_code <= res.code;
      out_kind <= res.kind;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_code;
  assign m_axis_tuser  = out_kind;

`ifndef ASSERT_OFF
  a_start: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=> (state == ST_SHIFT) && (step == '0))
    else $error("evaluation did not start after last word");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SHIFT) && (step == LAST_STEP)) |=> (state == ST_DONE))
    else $error("chain rotation did not end after fourteen steps");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (cells[0] == ASCII_ZERO) && (cells[STORE_LEN-1] == ASCII_ZERO))
    else $error("store not cleared after rotation");

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (count == '0) && m_axis_tvalid)
    else $error("count not cleared or result lost on load");
`endif

endmodule

FILE: sim/tb_tax_id_validate_pack.sv
`timescale 1ns / 1ps
// self-checking bench for tax_id_validate_pack: streams masked ids and compares each
// packed code and kind against a built-in mod-11 check and packing predictor
// depends on tiv_pkg and tax_id_validate_pack

module tb_tax_id_validate_pack;
  import tiv_pkg::*;

  localparam int ID_SLOTS = 14;
  localparam int CYCLE_LIMIT = 400000;
  localparam bit [63:0] ELEVEN_TAG = 64'h8000_0000_0000_0000;
  localparam bit [63:0] DIGITS_TAG = 64'hC000_0000_0000_0000;

  typedef bit [7:0] id_store_t [ID_SLOTS];
  typedef struct {
    bit [7:0] ch;
    bit       last;
  } id_char_t;
  typedef struct {
    bit [63:0]  code;
    code_kind_t kind;
  } packed_id_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_in
  logic        s_axis_tlast = 1'b0;    // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;           // [63:0] packed_code
  logic [1:0]  m_axis_tuser;           // [1:0] code_kind

  id_char_t   char_backlog[$];
  packed_id_t expected_codes[$];
  id_store_t  id_chars;
  bit [3:0]   id_len;
  id_char_t   drive_char;
  packed_id_t want;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;

  tax_id_validate_pack DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------- predictor ----------------

  function automatic bit char_is_digit(bit [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit char_is_alnum(bit [7:0] c);
    bit [7:0] lc;
    lc = c | 8'h20;
    return char_is_digit(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
           && lc == lc;
  endfunction

  // 0..35, letters in either case
  function automatic int base36_digit(bit [7:0] c);
    if (char_is_digit(c)) return int'(c) - 48;
    return int'(c | 8'h20) - 8'h61 + 10;
  endfunction

  // letters weigh in as their upper-case code minus 48
  function automatic int check_weight_value(bit [7:0] c);
    if (char_is_digit(c)) return int'(c) - 48;
    return int'(c & 8'hDF) - 48;
  endfunction

  // weights 5,4,3,2,9..2 and 6,5,4,3,2,9..3 follow a simple pattern
  function automatic void mod11_check_pair(input id_store_t s, output int d1, output int d2);
    int s1;
    int s2;
    int v;
    s1 = 0;
    s2 = 0;
    for (int i = 0; i < 12; i++) begin
      v = check_weight_value(s[i]);
      s1 += ((i < 4) ? 5 - i : 13 - i) * v;
      s2 += ((i < 5) ? 6 - i : 14 - i) * v;
    end
    d1 = s1 % 11;
    d1 = (d1 > 1) ? 11 - d1 : 0;
    d2 = (s2 + 2 * d1) % 11;
    d2 = (d2 > 1) ? 11 - d2 : 0;
  endfunction

  function automatic bit [63:0] radix_value(id_store_t s, int from, int len, int base);
    bit [63:0] acc;
    acc = 0;
    for (int i = from; i < from + len; i++) acc = acc * base + base36_digit(s[i]);
    return acc;
  endfunction

  function automatic packed_id_t classify_id(id_store_t s, bit [3:0] n);
    packed_id_t r;
    int d1;
    int d2;
    bit all_digits;
    r.code = CODE_INVALID;
    r.kind = KIND_INVALID;
    if (n > 4'd14) return r;
    mod11_check_pair(s, d1, d2);
    if (char_is_digit(s[12]) && char_is_digit(s[13]) &&
        d1 == int'(s[12]) - 48 && d2 == int'(s[13]) - 48) begin
      r.code = radix_value(s, 0, 12, 36);
      r.kind = KIND_CHECKED;
      return r;
    end
    if (n == 4'd14) return r;
    if (n <= 4'd11) begin
      r.code = ELEVEN_TAG + radix_value(s, 3, 11, 36);
      r.kind = KIND_ELEVEN;
      return r;
    end
    all_digits = 1'b1;
    for (int i = 1; i < ID_SLOTS; i++) if (!char_is_digit(s[i])) all_digits = 1'b0;
    if (all_digits) begin
      r.code = DIGITS_TAG + radix_value(s, 1, 13, 10);
      r.kind = KIND_DIGITS;
    end
    return r;
  endfunction

  function automatic void clear_id();
    foreach (id_chars[i]) id_chars[i] = 8'h30;
    id_len = 4'd0;
  endfunction

  function automatic void fold_char(bit [7:0] c, bit is_last);
    if (char_is_alnum(c)) begin
      for (int i = 0; i < ID_SLOTS - 1; i++) id_chars[i] = id_chars[i + 1];
      id_chars[ID_SLOTS - 1] = c;
      if (id_len != 4'd15) id_len++;
    end
    if (is_last) begin
      expected_codes.push_back(classify_id(id_chars, id_len));
      clear_id();
    end
  endfunction

  // ---------------- stimulus ----------------

  function automatic bit [7:0] rand_alnum(bit digits_only);
    int idx;
    idx = digits_only ? $urandom_range(9) : $urandom_range(61);
    if (idx < 10) return 8'(8'h30 + idx);
    if (idx < 36) return 8'(8'h41 + idx - 10);
    return 8'(8'h61 + idx - 36);
  endfunction

  function automatic bit [7:0] rand_noise();
    bit [7:0] c;
    c = 8'($urandom_range(255));
    while (char_is_alnum(c)) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic void queue_text(string t);
    id_char_t item;
    for (int i = 0; i < t.len(); i++) begin
      item.ch = t[i];
      item.last = (i == t.len() - 1);
      char_backlog.push_back(item);
    end
  endfunction

  // one id of random shape; returns the number of words queued
  function automatic int queue_random_id();
    bit [7:0]  body[$];
    id_store_t s;
    id_char_t  item;
    int        pick;
    int        n;
    int        d1;
    int        d2;
    int        noise_pct;
    int        words;
    pick = $urandom_range(99);
    noise_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(30);
    words = 0;
    if (pick < 40) begin
      // well-formed checked id, sometimes with one check digit off
      n = ($urandom_range(3) == 0) ? $urandom_range(2, 13) : 14;
      foreach (s[i]) s[i] = 8'h30;
      for (int k = 0; k < n - 2; k++) begin
        body.push_back(rand_alnum($urandom_range(1)));
        s[14 - n + k] = body[k];
      end
      mod11_check_pair(s, d1, d2);
      if (pick >= 32) d2 = (d2 + $urandom_range(1, 9)) % 10;
      body.push_back(8'(8'h30 + d1));
      body.push_back(8'(8'h30 + d2));
    end else if (pick < 60) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(14) : $urandom_range(12, 13);
      for (int k = 0; k < n; k++) body.push_back(rand_alnum(1'b1));
      // occasionally replace one digit with a random letter or digit
      if (n != 0 && $urandom_range(4) == 0) body[$urandom_range(n - 1)] = rand_alnum(1'b0);
    end else if (pick < 85) begin
      n = $urandom_range(14);
      for (int k = 0; k < n; k++) body.push_back(rand_alnum($urandom_range(3) == 0));
    end else begin
      n = $urandom_range(15, 22);
      for (int k = 0; k < n; k++) body.push_back(rand_alnum($urandom_range(1)));
    end
    foreach (body[k]) begin
      if ($urandom_range(99) < noise_pct) begin
        item.ch = rand_noise();
        item.last = 1'b0;
        char_backlog.push_back(item);
        words++;
      end
      item.ch = body[k];
      item.last = 1'b0;
      char_backlog.push_back(item);
      words++;
    end
    // the final word is sometimes a separator that gets dropped
    if (body.size() == 0 || $urandom_range(7) == 0) begin
      item.ch = rand_noise();
      item.last = 1'b1;
      char_backlog.push_back(item);
      words++;
    end else begin
      char_backlog[char_backlog.size() - 1].last = 1'b1;
    end
    return words;
  endfunction

  // ---------------- driver, receiver, monitor ----------------

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) fold_char(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (char_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_char = char_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= drive_char.ch;
          s_axis_tlast  <= drive_char.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual code=%h kind=%0d",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = expected_codes.pop_front();
        if (m_axis_tdata !== want.code) begin
          $display("%0t: packed_code mismatch, expected %h actual %h",
                   $time, want.code, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.kind) begin
          $display("%0t: code_kind mismatch, expected %0d actual %0d",
                   $time, want.kind, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    int queued;
    id_char_t item;
    clear_id();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty ids, one ending on a NUL and one on 0xff
    item.ch = 8'h00;
    item.last = 1'b1;
    char_backlog.push_back(item);
    item.ch = 8'hFF;
    char_backlog.push_back(item);
    // mixed case with every separator that borders a letter or digit range
    queue_text("Za-9{A`z@0[/:");
    queue_text("5550001112223");

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct = 34;
          recv_stall_pct = 34;
        end
      endcase
      queued = 0;
      while (queued < 330) queued += queue_random_id();
      while (char_backlog.size() != 0 || s_axis_tvalid) @(posedge clk);
    end

    while (expected_codes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/tiv_pkg.sv
sv/tiv_cell.sv
sv/tiv_eval.sv
sv/tax_id_validate_pack.sv
sim/tb_tax_id_validate_pack.sv
